@@ rtl/kumt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key usage mask table package
// Shared sizes, control types and the light-bit helper function of the key table.
// ----------------------------------------------------------------------------
package kumt_pkg;

   localparam int CAPACITY = 128;
   localparam int KEY_W    = 32;
   localparam int LIGHT_W  = 5;
   localparam int MASK_W   = 8;
   localparam int SLOT_W   = 7;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int REQ_DATA_W = ((KEY_W + LIGHT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((1 + SLOT_W + 7) / 8) * 8;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [MASK_W-1:0] bit_mask;
      logic              cmp;
      logic              upd;
      logic              ins;
   } cell_ctrl_type;

   function automatic logic [MASK_W-1:0] light_bit(input logic [LIGHT_W-1:0] light);
      logic [MASK_W-1:0] result;
      result = '0;
      if (light < LIGHT_W'(MASK_W)) begin
         result[light[$clog2(MASK_W)-1:0]] = 1'b1;
      end
      return result;
   endfunction

endpackage

@@ rtl/kumt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key table cell
// One table entry: stored key, valid flag and usage mask, with its own key
// comparator. The first free cell of the row takes an inserted key.
// ----------------------------------------------------------------------------
module kumt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  kumt_pkg::cell_ctrl_type ctrl,
   input  logic                   prev_valid,
   output logic                   valid,
   output logic                   match
);
   import kumt_pkg::*;

   logic [KEY_W-1:0]  key_ff;
   logic [KEY_W-1:0]  key_in;
   logic [MASK_W-1:0] mask_ff;
   logic [MASK_W-1:0] mask_in;
   logic              valid_ff;
   logic              valid_in;
   logic              match_ff;
   logic              match_in;
   logic              head;

   assign head = !valid_ff && prev_valid;

   always_comb begin
      key_in   = key_ff;
      mask_in  = mask_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (ctrl.cmp) begin
         match_in = valid_ff && (key_ff == ctrl.key);
      end
      if (ctrl.upd && match_ff) begin
         mask_in = mask_ff | ctrl.bit_mask;
      end
      if (ctrl.ins && head) begin
         key_in   = ctrl.key;
         valid_in = 1'b1;
         mask_in  = mask_ff | ctrl.bit_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         mask_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         mask_ff  <= mask_in;
      end
      key_ff <= key_in;
   end

   assign valid = valid_ff;
   assign match = match_ff;

endmodule

@@ rtl/kumt_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key table match encoder
// Turns the row of match flags into a hit flag and the index of the hit.
// ----------------------------------------------------------------------------
module kumt_encoder (
   input  logic [kumt_pkg::CAPACITY-1:0] match_vec,
   output logic                          hit,
   output logic [kumt_pkg::IDX_W-1:0]    index
);
   import kumt_pkg::*;

   always_comb begin
      index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

   assign hit = |match_vec;

endmodule

@@ rtl/key_usage_mask_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key usage mask table
// Find-or-insert table of 32-bit keys, each entry carrying an 8-bit usage
// mask, built as a row of entry cells with a comparator in each cell.
// ----------------------------------------------------------------------------
// The request channel carries one key and one light index per beat. Each
// request looks the key up in every cell at once; on a hit the light bit is
// ORed into that entry's mask, on a miss the key is written to the first
// free cell with the light bit set, unless the table is full.
// The response channel returns one beat per request: a status bit (ok or
// full) and the slot of the matched or new entry, zero when full.
// A response is registered in the write-back state, after the compare state
// that its accepted request beat enters. A new request is taken in the cycle
// in which the previous one writes back, so each request in turn passes the
// compare state and the write-back state of the cell row.
// Reset empties the table at once: all valid flags, masks and the entry
// count clear, and no response is pending.
// When the receiver stalls, the finished response waits in the output
// register; the next request may still be accepted and compared, and its
// write-back waits until the output register is free.
// ----------------------------------------------------------------------------
module key_usage_mask_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: key (32), light_index (5), zero fill (3).
   input  logic [kumt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: status (1), slot (7).
   output logic [kumt_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import kumt_pkg::*;

   state_type              state_ff;
   state_type              state_in;
   logic [KEY_W-1:0]       key_ff;
   logic [KEY_W-1:0]       key_in;
   logic [MASK_W-1:0]      bit_ff;
   logic [MASK_W-1:0]      bit_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_status_ff;
   logic                   rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic [SLOT_W-1:0]      rsp_slot_in;

   cell_ctrl_type          ctrl;
   logic [CAPACITY-1:0]    valid_vec;
   logic [CAPACITY-1:0]    match_vec;
   logic                   hit;
   logic [IDX_W-1:0]       hit_index;
   logic                   full;
   logic                   out_free;
   logic                   accept;
   logic                   rsp_load;
   logic [IDX_W-1:0]       slot_index;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;
   assign slot_index = hit ? hit_index : count_ff[IDX_W-1:0];
   assign slot_ext   = (IDX_W + SLOT_W)'(slot_index);

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      rsp_load      = 1'b0;
      ctrl.key      = key_ff;
      ctrl.bit_mask = bit_ff;
      ctrl.cmp      = 1'b0;
      ctrl.upd      = 1'b0;
      ctrl.ins      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            ctrl.cmp = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_load   = 1'b1;
               req_tready = 1'b1;
               ctrl.upd   = hit;
               ctrl.ins   = !hit && !full;
               state_in   = req_tvalid ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      key_in        = key_ff;
      bit_in        = bit_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (accept) begin
         key_in = req_tdata[KEY_W-1:0];
         bit_in = light_bit(req_tdata[KEY_W+LIGHT_W-1:KEY_W]);
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (!hit && full) begin
            rsp_status_in = STATUS_FULL;
            rsp_slot_in   = '0;
         end else begin
            rsp_status_in = STATUS_OK;
            rsp_slot_in   = slot_ext[SLOT_W-1:0];
         end
      end
      if (ctrl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff        <= key_in;
      bit_ff        <= bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic prev_valid;
      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_next
         assign prev_valid = valid_vec[i-1];
      end
      kumt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_valid),
         .valid      (valid_vec[i]),
         .match      (match_vec[i])
      );
   end

   kumt_encoder u_encoder (
      .match_vec (match_vec),
      .hit       (hit),
      .index     (hit_index)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_slot_ff, rsp_status_ff});

   assert property (@(posedge clock) disable iff (reset)
      ctrl.ins |-> (count_ff < CNT_W'(CAPACITY)))
      else $error("insert issued while the table is full");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell matched the key");

   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("valid cells disagree with the entry count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_tvalid && $past(state_ff) == ST_UPDATE))
      else $error("response loaded outside the write-back cycle");

endmodule

@@ verif/key_usage_mask_table_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key usage mask table testbench
// Drives find-or-insert requests through the request stream, models the key
// table in the bench and checks every response beat, status and slot, in
// order. A short table of directed requests comes first. Random requests
// follow: fresh keys, repeats of stored keys and one-bit neighbors of stored
// keys. They fill the table and then keep hitting it once it is full.
// Both streams idle at random, and one long receiver hold-off backs up the
// block.
// ----------------------------------------------------------------------------
module key_usage_mask_table_unit_tb;
   import kumt_pkg::*;

   localparam int LIMIT_CYCLES    = 400000;
   localparam int RANDOM_REQUESTS = 800;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int NUM_VECTORS     = 14;

   typedef struct packed {
      logic              status;
      logic [SLOT_W-1:0] slot;
   } outcome_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LIGHT_W-1:0] light;
      logic               typed;
      outcome_type        want;
   } vector_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_MOSTLY,
      RX_SPARSE,
      RX_TOGGLE
   } rx_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // Fields from bit 0: key (32), light_index (5), zero fill (3).
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // Fields from bit 0: status (1), slot (7).
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [KEY_W-1:0]  known_keys [CAPACITY];
   logic [MASK_W-1:0] usage_masks [CAPACITY];
   int                entry_total;

   outcome_type awaited_outcomes [$];
   int          mismatch_count;
   int          burst_left;
   bit          valid_up;
   bit          hold_off_req;

   vector_type vectors [NUM_VECTORS] = '{
      {32'h0000_0000, 5'd0,  1'b1, STATUS_OK, 7'd0},
      {32'hFFFF_FFFF, 5'd31, 1'b1, STATUS_OK, 7'd1},
      {32'h0000_0000, 5'd7,  1'b1, STATUS_OK, 7'd0},
      {32'hFFFF_FFFF, 5'd8,  1'b1, STATUS_OK, 7'd1},
      {32'h0000_0001, 5'd1,  1'b1, STATUS_OK, 7'd2},
      {32'h8000_0000, 5'd2,  1'b1, STATUS_OK, 7'd3},
      {32'h7FFF_FFFF, 5'd3,  1'b1, STATUS_OK, 7'd4},
      {32'hA5A5_A5A5, 5'd4,  1'b1, STATUS_OK, 7'd5},
      {32'h5A5A_5A5A, 5'd5,  1'b1, STATUS_OK, 7'd6},
      {32'h8000_0000, 5'd6,  1'b1, STATUS_OK, 7'd3},
      {32'h0000_0001, 5'd16, 1'b1, STATUS_OK, 7'd2},
      {32'h0000_0000, 5'd30, 1'b1, STATUS_OK, 7'd0},
      {32'hFFFF_FFFE, 5'd9,  1'b0, STATUS_OK, 7'd0},
      {32'hA5A5_A5A4, 5'd15, 1'b0, STATUS_OK, 7'd0}
   };

   key_usage_mask_table_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic outcome_type find_or_insert(input logic [KEY_W-1:0] key,
                                                  input logic [LIGHT_W-1:0] light);
      logic [MASK_W-1:0] usage_bit;
      outcome_type       result;
      usage_bit = (light < MASK_W) ? (MASK_W'(1) << light) : '0;
      result.status = STATUS_OK;
      result.slot = '0;
      for (int i = 0; i < entry_total; i++) begin
         if (known_keys[i] == key) begin
            usage_masks[i] = usage_masks[i] | usage_bit;
            result.slot = SLOT_W'(i);
            return result;
         end
      end
      if (entry_total >= CAPACITY) begin
         result.status = STATUS_FULL;
         return result;
      end
      known_keys[entry_total] = key;
      usage_masks[entry_total] = usage_masks[entry_total] | usage_bit;
      result.slot = SLOT_W'(entry_total);
      entry_total++;
      return result;
   endfunction

   task automatic send_request(input logic [KEY_W-1:0] key, input logic [LIGHT_W-1:0] light,
                               input logic typed, input outcome_type typed_want);
      outcome_type predicted;
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'({light, key});
      valid_up = 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = find_or_insert(key, light);
      awaited_outcomes.push_back(typed ? typed_want : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic drain_responses();
      if (valid_up) begin
         req_tvalid <= 1'b0;
         valid_up = 1'b0;
      end
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   task automatic note_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("Mismatch on %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
      end
   endtask

   initial begin : stimulus
      logic [KEY_W-1:0]   key;
      logic [LIGHT_W-1:0] light;
      int                 pick;
      int                 idx;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      entry_total = 0;
      mismatch_count = 0;
      burst_left = 0;
      valid_up = 1'b0;
      hold_off_req = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         usage_masks[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) begin
         send_request(vectors[i].key, vectors[i].light, vectors[i].typed, vectors[i].want);
      end
      drain_responses();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 120) begin
            hold_off_req = 1'b1;
         end
         if (n == 500) begin
            drain_responses();
         end
         pick = $urandom_range(0, 99);
         if (entry_total == 0 || pick < 45) begin
            key = $urandom;
         end else begin
            idx = $urandom_range(0, entry_total - 1);
            key = known_keys[idx];
            if (pick >= 80) begin
               key = key ^ (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
            end
         end
         light = LIGHT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(8, 31)
                                                      : $urandom_range(0, 7));
         send_request(key, light, 1'b0, '0);
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : receiver
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      bit          toggle;
      rsp_tready <= 1'b0;
      mode = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      toggle = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(32, 200);
            end
            mode_left--;
            case (mode)
               RX_OPEN: begin
                  rsp_tready <= 1'b1;
               end
               RX_MOSTLY: begin
                  rsp_tready <= ($urandom_range(0, 3) != 0);
               end
               RX_SPARSE: begin
                  rsp_tready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  toggle = !toggle;
                  rsp_tready <= toggle;
               end
            endcase
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tdata[0];
         got.slot = rsp_tdata[SLOT_W:1];
         if (awaited_outcomes.size() == 0) begin
            note_mismatch("unrequested beat slot", -1, got.slot);
         end else begin
            want = awaited_outcomes.pop_front();
            if (got.status !== want.status) begin
               note_mismatch("status", want.status, got.status);
            end
            if (got.slot !== want.slot) begin
               note_mismatch("slot", want.slot, got.slot);
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      do begin
         @(posedge clock);
         cycles++;
      end while (cycles < LIMIT_CYCLES);
      $display("Timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ key_usage_mask_table_unit.f @@
rtl/kumt_pkg.sv
rtl/kumt_cell.sv
rtl/kumt_encoder.sv
rtl/key_usage_mask_table_unit.sv
verif/key_usage_mask_table_unit_tb.sv
